// ===== src/vom_pkg.sv =====
// ----------------------------------------------------------------------------
// vom_pkg: shared definitions for the voxel occlusion mask block
// Extents, widths, register indexes, the geometry and status structs, and
// the extent clamp used by the configuration logic.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package vom_pkg;

    // Volume limits.
    localparam int MAX_EXTENT = 32;
    localparam int MAX_PLANE  = 1024;

    // Configuration port.
    localparam int CFG_W     = 6;
    localparam int DATA_W    = 32;
    localparam int ADDR_W    = 4;
    localparam int REG_IDX_W = 2;
    localparam int CFG_RESET = 18;

    localparam logic [REG_IDX_W-1:0] REG_SIZE_X = REG_IDX_W'(0);
    localparam logic [REG_IDX_W-1:0] REG_SIZE_Y = REG_IDX_W'(1);
    localparam logic [REG_IDX_W-1:0] REG_SIZE_Z = REG_IDX_W'(2);

    // Derived widths.
    localparam int EXT_W   = $clog2(MAX_EXTENT + 1);
    localparam int POS_W   = $clog2(MAX_EXTENT);
    localparam int PLANE_W = $clog2(MAX_PLANE + 1);
    localparam int PROD_W  = 2 * EXT_W;

    // Largest usable x extent, so that three rows always fit one plane.
    localparam int X_LIM = (MAX_EXTENT < MAX_PLANE / 3) ? MAX_EXTENT : MAX_PLANE / 3;

    // Delay line sizing: long segments span plane - size_x, short ones size_x - 1.
    localparam int N_LONG      = MAX_PLANE - 3;
    localparam int N_SHORT     = X_LIM - 1;
    localparam int LONG_IDX_W  = $clog2(N_LONG);
    localparam int SHORT_IDX_W = $clog2(N_SHORT);

    // Result fields.
    localparam int MASK_W    = 6;
    localparam int HID_W     = 15;
    localparam int COUNT_MAX = (2 ** HID_W) - 1;

    localparam int SIDE_NEG_X = 0;
    localparam int SIDE_POS_X = 1;
    localparam int SIDE_NEG_Y = 2;
    localparam int SIDE_POS_Y = 3;
    localparam int SIDE_NEG_Z = 4;
    localparam int SIDE_POS_Z = 5;

    // Geometry after reset, with the same clamping as a register write.
    localparam int RST_X0   = (CFG_RESET < 3) ? 3 : ((CFG_RESET > X_LIM) ? X_LIM : CFG_RESET);
    localparam int RST_X    = RST_X0;
    localparam int RST_Y0   = (CFG_RESET < 3) ? 3 :
                              ((CFG_RESET > MAX_EXTENT) ? MAX_EXTENT : CFG_RESET);
    localparam int RST_YLIM = MAX_PLANE / RST_X;
    localparam int RST_Y    = (RST_Y0 > RST_YLIM) ? RST_YLIM : RST_Y0;
    localparam int RST_Z    = RST_Y0;
    localparam int RST_PLANE = RST_X * RST_Y;

    typedef struct packed {
        logic [POS_W-1:0]       x_last;
        logic [POS_W-1:0]       y_last;
        logic [POS_W-1:0]       z_last;
        logic [POS_W-1:0]       x_inner_last;
        logic [POS_W-1:0]       y_inner_last;
        logic [LONG_IDX_W-1:0]  inj_long;
        logic [SHORT_IDX_W-1:0] inj_short;
    } geom_t;

    localparam geom_t GEOM_RESET = '{
        x_last:       POS_W'(RST_X - 1),
        y_last:       POS_W'(RST_Y - 1),
        z_last:       POS_W'(RST_Z - 1),
        x_inner_last: POS_W'(RST_X - 2),
        y_inner_last: POS_W'(RST_Y - 2),
        inj_long:     LONG_IDX_W'(RST_PLANE - RST_X - 1),
        inj_short:    SHORT_IDX_W'(RST_X - 2)
    };

    typedef struct packed {
        logic plus_y;
        logic plus_x;
        logic centre;
        logic minus_x;
        logic minus_y;
        logic minus_z;
    } tap_t;

    typedef struct packed {
        logic             emit;
        logic             last;
        logic [HID_W-1:0] hidden;
    } stat_t;

    // Clamp a raw extent into [3, hi].
    function automatic logic [EXT_W-1:0] clamp_extent(input logic [CFG_W-1:0] v,
                                                      input int hi);
        int vi;
        vi = int'(v);
        if (vi < 3) begin
            vi = 3;
        end else if (vi > hi) begin
            vi = hi;
        end
        return EXT_W'(vi);
    endfunction

endpackage

`default_nettype wire

// ===== src/vom_cell.sv =====
// ----------------------------------------------------------------------------
// vom_cell: one stage of the occluder delay line
// Holds one occluder bit; on each accepted word it either takes the segment
// input (when it is the entry point) or its upstream neighbour's bit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module vom_cell (
    input  wire logic aclk,
    input  wire logic shift_en,
    input  wire logic load_seg,
    input  wire logic din_seg,
    input  wire logic din_next,
    output logic      q
);

    logic bit_reg;
    logic bit_next;

    assign bit_next = load_seg ? din_seg : din_next;

    always_ff @(posedge aclk) begin
        if (shift_en) begin
            bit_reg <= bit_next;
        end
    end

    assign q = bit_reg;

endmodule

`default_nettype wire

// ===== src/vom_tap_chain.sv =====
// ----------------------------------------------------------------------------
// vom_tap_chain: line store as a chain of cells with fixed neighbour taps
// Six segments in series give the delays plane-sx, plane-1, plane, plane+1,
// plane+sx and 2*plane; each variable segment enters at a configured cell.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module vom_tap_chain
    import vom_pkg::*;
(
    input  wire logic  aclk,
    input  wire logic  shift_en,
    input  wire logic  din,
    input  wire geom_t geom,
    output tap_t       taps
);

    logic [N_LONG-1:0]  long_q  [2];
    logic [N_SHORT-1:0] short_q [2];
    logic [1:0]         long_in;
    logic [1:0]         short_in;
    logic               c_q;
    logic               d_q;

    // Segment order: long0, short0, single, single, short1, long1.
    assign long_in[0]  = din;
    assign short_in[0] = long_q[0][0];
    assign short_in[1] = d_q;
    assign long_in[1]  = short_q[1][0];

    for (genvar s = 0; s < 2; s++) begin : g_seg
        for (genvar i = 0; i < N_LONG; i++) begin : g_long
            logic nxt;
            if (i == N_LONG - 1) begin : g_end
                assign nxt = long_in[s];
            end else begin : g_mid
                assign nxt = long_q[s][i+1];
            end
            vom_cell u_cell (
                .aclk     (aclk),
                .shift_en (shift_en),
                .load_seg (geom.inj_long == LONG_IDX_W'(i)),
                .din_seg  (long_in[s]),
                .din_next (nxt),
                .q        (long_q[s][i])
            );
        end
        for (genvar i = 0; i < N_SHORT; i++) begin : g_short
            logic nxt;
            if (i == N_SHORT - 1) begin : g_end
                assign nxt = short_in[s];
            end else begin : g_mid
                assign nxt = short_q[s][i+1];
            end
            vom_cell u_cell (
                .aclk     (aclk),
                .shift_en (shift_en),
                .load_seg (geom.inj_short == SHORT_IDX_W'(i)),
                .din_seg  (short_in[s]),
                .din_next (nxt),
                .q        (short_q[s][i])
            );
        end
    end

    vom_cell u_centre (
        .aclk     (aclk),
        .shift_en (shift_en),
        .load_seg (1'b1),
        .din_seg  (short_q[0][0]),
        .din_next (short_q[0][0]),
        .q        (c_q)
    );

    vom_cell u_minus_x (
        .aclk     (aclk),
        .shift_en (shift_en),
        .load_seg (1'b1),
        .din_seg  (c_q),
        .din_next (c_q),
        .q        (d_q)
    );

    always_comb begin
        taps.plus_y  = long_q[0][0];
        taps.plus_x  = short_q[0][0];
        taps.centre  = c_q;
        taps.minus_x = d_q;
        taps.minus_y = short_q[1][0];
        taps.minus_z = long_q[1][0];
    end

endmodule

`default_nettype wire

// ===== src/vom_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// vom_cfg_regs: extent registers and derived volume geometry
// Holds the raw extents and, on every extent register write, registers the
// clamped geometry (wrap points, interior bounds and delay line entry points).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module vom_cfg_regs
    import vom_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output logic      [DATA_W-1:0] prdata,
    output geom_t                  geom,
    output logic                   restart
);

    logic [CFG_W-1:0]     size_x_reg, size_x_next;
    logic [CFG_W-1:0]     size_y_reg, size_y_next;
    logic [CFG_W-1:0]     size_z_reg, size_z_next;
    geom_t                geom_reg, geom_next;
    logic                 wr_en;
    logic [REG_IDX_W-1:0] reg_idx;
    logic [EXT_W-1:0]     sx, sy, cy, sz;
    logic [PLANE_W-1:0]   ylim_tab [2**EXT_W];
    logic [PLANE_W-1:0]   ylim;
    logic [PROD_W-1:0]    prod;
    logic [PLANE_W-1:0]   plane;

    // Largest y extent that still fits one plane, for each x extent.
    for (genvar gi = 0; gi < 2**EXT_W; gi++) begin : g_ylim
        localparam int Q = MAX_PLANE / ((gi < 3) ? 3 : gi);
        assign ylim_tab[gi] = PLANE_W'(Q);
    end

    assign reg_idx = paddr[ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite;

    always_comb begin
        size_x_next = size_x_reg;
        size_y_next = size_y_reg;
        size_z_next = size_z_reg;
        restart     = 1'b0;
        if (wr_en) begin
            unique case (reg_idx)
                REG_SIZE_X: begin
                    size_x_next = pwdata[CFG_W-1:0];
                    restart     = 1'b1;
                end
                REG_SIZE_Y: begin
                    size_y_next = pwdata[CFG_W-1:0];
                    restart     = 1'b1;
                end
                REG_SIZE_Z: begin
                    size_z_next = pwdata[CFG_W-1:0];
                    restart     = 1'b1;
                end
                default: begin
                    restart = 1'b0;
                end
            endcase
        end
    end

    always_comb begin
        sx   = clamp_extent(size_x_next, X_LIM);
        cy   = clamp_extent(size_y_next, MAX_EXTENT);
        sz   = clamp_extent(size_z_next, MAX_EXTENT);
        ylim = ylim_tab[sx];
        sy   = (PLANE_W'(cy) > ylim) ? EXT_W'(ylim) : cy;
        prod  = PROD_W'(sx) * PROD_W'(sy);
        plane = PLANE_W'(prod);

        geom_next.x_last       = POS_W'(sx - EXT_W'(1));
        geom_next.y_last       = POS_W'(sy - EXT_W'(1));
        geom_next.z_last       = POS_W'(sz - EXT_W'(1));
        geom_next.x_inner_last = POS_W'(sx - EXT_W'(2));
        geom_next.y_inner_last = POS_W'(sy - EXT_W'(2));
        geom_next.inj_long     = LONG_IDX_W'(plane - PLANE_W'(sx) - PLANE_W'(1));
        geom_next.inj_short    = SHORT_IDX_W'(sx - EXT_W'(2));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            size_x_reg <= CFG_W'(CFG_RESET);
            size_y_reg <= CFG_W'(CFG_RESET);
            size_z_reg <= CFG_W'(CFG_RESET);
            geom_reg   <= GEOM_RESET;
        end else if (restart) begin
            size_x_reg <= size_x_next;
            size_y_reg <= size_y_next;
            size_z_reg <= size_z_next;
            geom_reg   <= geom_next;
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_SIZE_X: prdata = DATA_W'(size_x_reg);
            REG_SIZE_Y: prdata = DATA_W'(size_y_reg);
            REG_SIZE_Z: prdata = DATA_W'(size_z_reg);
            default:    prdata = '0;
        endcase
    end

    assign geom = geom_reg;

endmodule

`default_nettype wire

// ===== src/vom_raster_ctr.sv =====
// ----------------------------------------------------------------------------
// vom_raster_ctr: raster position and fully hidden count
// Tracks the position of the next voxel, flags interior voxels and the last
// one, and keeps the saturating per-volume count of fully hidden voxels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module vom_raster_ctr
    import vom_pkg::*;
(
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  step,
    input  wire logic  restart,
    input  wire logic  full,
    input  wire geom_t geom,
    output stat_t      stat
);

    logic [POS_W-1:0] pos_x_reg, pos_x_next;
    logic [POS_W-1:0] pos_y_reg, pos_y_next;
    logic [POS_W-1:0] pos_z_reg, pos_z_next;
    logic [HID_W-1:0] total_reg, total_next;
    logic             x_wrap, y_wrap, z_wrap;
    logic             interior;
    logic [HID_W-1:0] hidden;

    assign interior = (pos_z_reg >= POS_W'(2)) &&
                      (pos_x_reg != '0) && (pos_x_reg <= geom.x_inner_last) &&
                      (pos_y_reg != '0) && (pos_y_reg <= geom.y_inner_last);

    assign hidden = (full && (total_reg < HID_W'(COUNT_MAX))) ? total_reg + HID_W'(1)
                                                              : total_reg;

    assign x_wrap = (pos_x_reg == geom.x_last);
    assign y_wrap = x_wrap && (pos_y_reg == geom.y_last);
    assign z_wrap = y_wrap && (pos_z_reg == geom.z_last);

    always_comb begin
        pos_x_next = x_wrap ? '0 : pos_x_reg + POS_W'(1);
        pos_y_next = pos_y_reg;
        pos_z_next = pos_z_reg;
        total_next = interior ? hidden : total_reg;
        if (x_wrap) begin
            pos_y_next = y_wrap ? '0 : pos_y_reg + POS_W'(1);
        end
        if (y_wrap) begin
            pos_z_next = z_wrap ? '0 : pos_z_reg + POS_W'(1);
        end
        if (z_wrap) begin
            total_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || restart) begin
            pos_x_reg <= '0;
            pos_y_reg <= '0;
            pos_z_reg <= '0;
            total_reg <= '0;
        end else if (step) begin
            pos_x_reg <= pos_x_next;
            pos_y_reg <= pos_y_next;
            pos_z_reg <= pos_z_next;
            total_reg <= total_next;
        end
    end

    always_comb begin
        stat.emit   = interior;
        stat.last   = (pos_z_reg == geom.z_last) && (pos_y_reg == geom.y_inner_last) &&
                      (pos_x_reg == geom.x_inner_last);
        stat.hidden = hidden;
    end

endmodule

`default_nettype wire

// ===== src/voxel_occlusion_mask_top.sv =====
// ----------------------------------------------------------------------------
// voxel_occlusion_mask_top: six-neighbour occlusion mask over a voxel stream
// Takes occluder bits of a padded volume in raster order and reports, for
// each interior voxel, its face-neighbour occluder mask and hidden count.
// ----------------------------------------------------------------------------
//
//   Channel   Ports                 Direction  Word
//   --------  --------------------  ---------  --------------------------------
//   input     s_valid/s_ready       in         is_occluder of next voxel
//   result    m_valid/m_ready       out        self, side mask, hidden, count,
//                                              last
//   config    psel/penable/pwrite   in         size_x, size_y, size_z at 0/4/8
//
// One input word is taken per clock while s_ready is high. A voxel's result
// is reported in the cycle after the word holding its +z neighbour is
// accepted, from a single output register; border voxels produce no word.
// The line store is a chain of single-bit cells that shifts once per
// accepted word; each neighbour is read at a fixed cell, and the segment
// lengths follow the configured extents through per-segment entry points.
// Reset is synchronous and active low; it clears the position, the count
// and the output valid, and loads the default extents of 18.
// When the output register is full and not taken, s_ready falls and the
// chain holds; a write to an extent register restarts the volume.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module voxel_occlusion_mask_top
    import vom_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,

    // Configuration port.
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output logic      [DATA_W-1:0] prdata,
    output logic                   pready,

    // Input word: one occluder bit per voxel.
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic              s_is_occluder,

    // Result word: one per interior voxel.
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic                   m_self_occluder,
    output logic      [MASK_W-1:0] m_side_mask,
    output logic                   m_fully_hidden,
    output logic      [HID_W-1:0]  m_hidden_count,
    output logic                   m_last_voxel
);

    geom_t             geom;
    logic              restart;
    tap_t              taps;
    stat_t             stat;
    logic              accept;
    logic [MASK_W-1:0] mask;
    logic              full;

    logic              m_valid_reg, m_valid_next;
    logic              self_reg;
    logic [MASK_W-1:0] mask_reg;
    logic              full_reg;
    logic [HID_W-1:0]  count_reg;
    logic              last_reg;

    assign pready = 1'b1;

    // The output register can take a new word whenever it is empty or being
    // drained in this cycle, so the input side never waits on a full stage
    // that is leaving.
    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    vom_cfg_regs u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .geom    (geom),
        .restart (restart)
    );

    vom_tap_chain u_chain (
        .aclk     (aclk),
        .shift_en (accept),
        .din      (s_is_occluder),
        .geom     (geom),
        .taps     (taps)
    );

    // The incoming word is the +z neighbour of the voxel at the centre tap.
    always_comb begin
        mask             = '0;
        mask[SIDE_NEG_X] = taps.minus_x;
        mask[SIDE_POS_X] = taps.plus_x;
        mask[SIDE_NEG_Y] = taps.minus_y;
        mask[SIDE_POS_Y] = taps.plus_y;
        mask[SIDE_NEG_Z] = taps.minus_z;
        mask[SIDE_POS_Z] = s_is_occluder;
        full             = &mask;
    end

    vom_raster_ctr u_ctr (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (accept),
        .restart (restart),
        .full    (full),
        .geom    (geom),
        .stat    (stat)
    );

    always_comb begin
        m_valid_next = m_valid_reg && !m_ready;
        if (accept && stat.emit) begin
            m_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload is loaded only with a reported voxel, so it holds while stalled.
    always_ff @(posedge aclk) begin
        if (accept && stat.emit) begin
            self_reg  <= taps.centre;
            mask_reg  <= mask;
            full_reg  <= full;
            count_reg <= stat.hidden;
            last_reg  <= stat.last;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_self_occluder = self_reg;
    assign m_side_mask     = mask_reg;
    assign m_fully_hidden  = full_reg;
    assign m_hidden_count  = count_reg;
    assign m_last_voxel    = last_reg;

endmodule

`default_nettype wire

// ===== sim/voxel_occlusion_mask_top_tb.sv =====
// ----------------------------------------------------------------------------
// voxel_occlusion_mask_top_tb: self-checking bench for the voxel occlusion mask
// Streams padded voxel volumes through the block, with random gaps on both
// channels. A behavioural copy of the line store predicts every result word,
// and each word is compared field by field as it leaves the block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module voxel_occlusion_mask_top_tb;
    import vom_pkg::*;

    localparam int STORE_LEN     = 2 * MAX_PLANE + 1;
    localparam int IDLE_PCT      = 31;
    localparam int ITEM_TARGET   = 1050;
    localparam int SETTLE_CYCLES = 8;
    localparam int DRAIN_LIMIT   = 2000;
    localparam int PRINT_LIMIT   = 20;

    // Index past the end of the register map; a write there must change nothing.
    localparam logic [REG_IDX_W-1:0] REG_SPARE = REG_IDX_W'(3);

    typedef struct packed {
        logic              self_occ;
        logic [MASK_W-1:0] sides;
        logic              hidden;
        logic [HID_W-1:0]  count;
        logic              last;
    } voxel_word_t;

    logic              aclk    = 1'b0;
    logic              aresetn = 1'b0;

    logic              psel    = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite  = 1'b0;
    logic [ADDR_W-1:0] paddr   = '0;
    logic [DATA_W-1:0] pwdata  = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    logic              s_valid       = 1'b0;
    logic              s_ready;
    logic              s_is_occluder = 1'b0;

    logic              m_valid;
    logic              m_ready = 1'b0;
    logic              m_self_occluder;
    logic [MASK_W-1:0] m_side_mask;
    logic              m_fully_hidden;
    logic [HID_W-1:0]  m_hidden_count;
    logic              m_last_voxel;

    // Occluder bits waiting to be sent, and result words waiting to arrive.
    logic              occ_queue[$];
    voxel_word_t       expected_words[$];

    int unsigned       idle_pct = IDLE_PCT;
    int unsigned       errors   = 0;
    int unsigned       queued   = 0;

    // Our own copy of the block's state: line store, raster position, count
    // of hidden voxels and the raw extent registers.
    bit                occ_store[STORE_LEN];
    int unsigned       store_ptr  = 0;
    int unsigned       pos_x      = 0;
    int unsigned       pos_y      = 0;
    int unsigned       pos_z      = 0;
    int unsigned       hidden_run = 0;
    logic [CFG_W-1:0]  ext_x      = CFG_W'(CFG_RESET);
    logic [CFG_W-1:0]  ext_y      = CFG_W'(CFG_RESET);
    logic [CFG_W-1:0]  ext_z      = CFG_W'(CFG_RESET);

    voxel_occlusion_mask_top u_top (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_is_occluder   (s_is_occluder),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_self_occluder (m_self_occluder),
        .m_side_mask     (m_side_mask),
        .m_fully_hidden  (m_fully_hidden),
        .m_hidden_count  (m_hidden_count),
        .m_last_voxel    (m_last_voxel)
    );

    always #5 aclk = ~aclk;

    // Usable extent: raw register value clamped to [3, MAX_EXTENT], and then
    // to whatever bound keeps one plane inside the line store.
    function automatic int unsigned fit_extent(input logic [CFG_W-1:0] raw,
                                               input int unsigned hi);
        int unsigned v;
        v = raw;
        if (v < 3) v = 3;
        if (v > MAX_EXTENT) v = MAX_EXTENT;
        if (v > hi) v = hi;
        return v;
    endfunction

    // Bit written 'back' words ago.
    function automatic bit store_tap(input int unsigned back);
        return occ_store[(store_ptr + STORE_LEN - back) % STORE_LEN];
    endfunction

    // Advance the line store by one voxel; when the voxel completes an
    // interior neighbourhood (its +z neighbour is this word) queue its result.
    task automatic predict_voxel(input logic occ);
        int unsigned sx, sy, sz, plane;
        voxel_word_t w;
        sx    = fit_extent(ext_x, MAX_PLANE / 3);
        sy    = fit_extent(ext_y, MAX_PLANE / sx);
        sz    = fit_extent(ext_z, MAX_EXTENT);
        plane = sx * sy;
        if (pos_x >= sx) pos_x = 0;
        if (pos_y >= sy) pos_y = 0;
        if (pos_z >= sz) pos_z = 0;
        if (pos_z >= 2 && pos_x >= 1 && pos_x <= sx - 2 && pos_y >= 1 && pos_y <= sy - 2) begin
            w.self_occ          = store_tap(plane);
            w.sides             = '0;
            w.sides[SIDE_NEG_X] = store_tap(plane + 1);
            w.sides[SIDE_POS_X] = store_tap(plane - 1);
            w.sides[SIDE_NEG_Y] = store_tap(plane + sx);
            w.sides[SIDE_POS_Y] = store_tap(plane - sx);
            w.sides[SIDE_NEG_Z] = store_tap(2 * plane);
            w.sides[SIDE_POS_Z] = occ;
            w.hidden            = &w.sides;
            if (w.hidden && hidden_run < COUNT_MAX) hidden_run++;
            w.count = HID_W'(hidden_run);
            w.last  = (pos_z == sz - 1 && pos_y == sy - 2 && pos_x == sx - 2);
            expected_words.push_back(w);
        end
        occ_store[store_ptr] = occ;
        store_ptr = (store_ptr + 1) % STORE_LEN;
        pos_x++;
        if (pos_x >= sx) begin
            pos_x = 0;
            pos_y++;
            if (pos_y >= sy) begin
                pos_y = 0;
                pos_z++;
                if (pos_z >= sz) begin
                    pos_z      = 0;
                    hidden_run = 0;
                end
            end
        end
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            if (errors < PRINT_LIMIT) begin
                $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
            end
            errors++;
        end
    endtask

    // ------------------------------------------------------------------------
    // Driver: presents the next queued occluder bit. A new word is only
    // considered once the current one has been taken, so valid never drops
    // under a pending word. While idle the data line carries noise.
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (occ_queue.size() != 0 && $urandom_range(99) >= idle_pct) begin
                s_valid       <= 1'b1;
                s_is_occluder <= occ_queue.pop_front();
            end else begin
                s_valid       <= 1'b0;
                s_is_occluder <= 1'($urandom_range(1));
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: follows register writes on the configuration bus, predicts on
    // every accepted input word and checks every accepted result word. All
    // sampling happens on the values present before the edge, so prediction
    // for the word taken at this edge always precedes its result.
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin : watch
        voxel_word_t want;
        bit          hit;
        m_ready <= ($urandom_range(99) >= idle_pct);
        if (aresetn) begin
            if (psel && penable && pwrite && pready) begin
                hit = 1'b1;
                case (paddr[ADDR_W-1:2])
                    REG_SIZE_X: ext_x = pwdata[CFG_W-1:0];
                    REG_SIZE_Y: ext_y = pwdata[CFG_W-1:0];
                    REG_SIZE_Z: ext_z = pwdata[CFG_W-1:0];
                    default:    hit = 1'b0;
                endcase
                // Any write to a real register, even of the same value,
                // starts a fresh volume.
                if (hit) begin
                    pos_x      = 0;
                    pos_y      = 0;
                    pos_z      = 0;
                    hidden_run = 0;
                end
            end
            if (s_valid && s_ready) begin
                predict_voxel(s_is_occluder);
            end
            if (m_valid && m_ready) begin
                if (expected_words.size() == 0) begin
                    if (errors < PRINT_LIMIT) begin
                        $display("%0t: unexpected result word, expected none actual mask %0d",
                                 $time, m_side_mask);
                    end
                    errors++;
                end else begin
                    want = expected_words.pop_front();
                    check_field("self_occluder", want.self_occ, m_self_occluder);
                    check_field("side_mask", want.sides, m_side_mask);
                    check_field("fully_hidden", want.hidden, m_fully_hidden);
                    check_field("hidden_count", want.count, m_hidden_count);
                    check_field("last_voxel", want.last, m_last_voxel);
                end
            end
        end
    end

    // Wait until every queued word has gone in and every predicted result has
    // come out, then let the output register drain before returning.
    task automatic settle();
        int unsigned waited;
        waited = 0;
        do begin
            @(negedge aclk);
            if (occ_queue.size() == 0 && !s_valid) waited++;
        end while ((occ_queue.size() != 0 || s_valid || expected_words.size() != 0) &&
                   waited < DRAIN_LIMIT);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    // One register write: setup cycle, then access cycle. Bits above the
    // register width carry noise that the block must ignore.
    task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'({idx, 2'b00});
        pwdata  <= ($urandom() << CFG_W) | DATA_W'(val);
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge aclk);
    endtask

    // Drain, program all three extents and report the number of voxels in
    // one padded volume of that shape.
    task automatic program_volume(input logic [CFG_W-1:0] rx, ry, rz,
                                  output int unsigned words);
        int unsigned nx, ny;
        settle();
        write_reg(REG_SIZE_X, rx);
        write_reg(REG_SIZE_Y, ry);
        write_reg(REG_SIZE_Z, rz);
        nx    = fit_extent(rx, MAX_PLANE / 3);
        ny    = fit_extent(ry, MAX_PLANE / nx);
        words = nx * ny * fit_extent(rz, MAX_EXTENT);
    endtask

    task automatic push_word(input bit occ);
        occ_queue.push_back(occ);
        queued++;
    endtask

    task automatic queue_words(input int unsigned count, input int unsigned density);
        repeat (count) push_word($urandom_range(99) < density);
    endtask

    // ------------------------------------------------------------------------
    // Stimulus. Every queue push happens just after a falling edge, well
    // away from the driver's pops.
    // ------------------------------------------------------------------------
    initial begin : stimulus
        int unsigned words, rx, ry, rz, round, density, vols, cut;
        round = 0;

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // With the default extents a short burst never leaves the first
        // planes, so no result words may appear.
        queue_words(20, 50);

        // Extents below the minimum clamp to a 3x3x3 volume with a single
        // interior voxel.
        program_volume(6'd0, 6'd2, 6'd1, words);
        queue_words(words, 100);                          // hidden, count 1, last
        for (int i = 0; i < 27; i++) push_word(i == 13);  // lone occluder
        for (int i = 0; i < 27; i++) push_word(i != 13);  // hollow centre
        queue_words(13, 50);                              // cut short by the rewrite

        // Rewriting the same values must still restart mid-volume.
        program_volume(6'd0, 6'd2, 6'd1, words);
        queue_words(10, 50);
        settle();
        // A write past the register map must leave the volume running.
        write_reg(REG_SPARE, 6'd5);
        queue_words(words - 10, 50);

        // The x extent at its top from an over-range value, streamed with
        // neither side pausing, then the y extent at its top.
        program_volume(6'd63, 6'd3, 6'd3, words);
        idle_pct = 0;
        queue_words(words, 90);
        settle();
        idle_pct = IDLE_PCT;
        program_volume(6'd3, 6'd33, 6'd3, words);
        queue_words(words, 90);

        // Random volumes: mostly small shapes, now and then one raw extent,
        // one to three volumes back to back and sometimes a truncated last one.
        while (queued < ITEM_TARGET) begin
            case ($urandom_range(9))
                0: begin
                    rx = $urandom_range(63);
                    ry = $urandom_range(3, 4);
                    rz = $urandom_range(3, 4);
                end
                1: begin
                    rx = $urandom_range(3, 4);
                    ry = $urandom_range(63);
                    rz = $urandom_range(3, 4);
                end
                2: begin
                    rx = $urandom_range(3, 4);
                    ry = $urandom_range(3, 4);
                    rz = $urandom_range(63);
                end
                default: begin
                    rx = $urandom_range(3, 8);
                    ry = $urandom_range(3, 8);
                    rz = $urandom_range(3, 6);
                end
            endcase
            program_volume(CFG_W'(rx), CFG_W'(ry), CFG_W'(rz), words);
            // The first round runs with neither side pausing.
            if (round == 0) idle_pct = 0;
            vols = $urandom_range(1, 3);
            for (int v = 0; v < vols; v++) begin
                case ($urandom_range(3))
                    0:       density = 10;
                    1:       density = 50;
                    2:       density = 85;
                    default: density = 100;
                endcase
                cut = words;
                if (v == vols - 1 && $urandom_range(4) == 0) cut = $urandom_range(1, words - 1);
                // Keep the whole run near the intended number of input words.
                if (queued >= ITEM_TARGET) begin
                    cut = 0;
                end else if (cut > ITEM_TARGET - queued) begin
                    cut = ITEM_TARGET - queued;
                end
                queue_words(cut, density);
            end
            // Hold the sender back until every result is home.
            if (round == 0 || $urandom_range(3) == 0) settle();
            idle_pct = IDLE_PCT;
            round++;
        end

        settle();
        if (expected_words.size() != 0) begin
            $display("%0t: %0d result words never arrived, expected %0d actual 0",
                     $time, expected_words.size(), expected_words.size());
        end
        if (errors == 0 && expected_words.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial begin
        #5_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule

// ===== files.f =====
src/vom_pkg.sv
src/vom_cell.sv
src/vom_tap_chain.sv
src/vom_cfg_regs.sv
src/vom_raster_ctr.sv
src/voxel_occlusion_mask_top.sv
sim/voxel_occlusion_mask_top_tb.sv
